// ===== rtl/core/grid_strip_index_generator_assert.svh =====
// Assertion macros shared by the strip index generator RTL.
`ifndef GRID_STRIP_INDEX_GENERATOR_ASSERT_SVH
`define GRID_STRIP_INDEX_GENERATOR_ASSERT_SVH

// Checked on every clock edge outside reset.
`define GSIG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define GSIG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/gsig_pkg.sv =====
// Types and constants for the grid strip index generator.
`timescale 1ns / 1ps
`default_nettype none

package gsig_pkg;

  localparam int unsigned MAX_LOG2 = 10;
  localparam int unsigned LOG2_W   = 4;
  localparam int unsigned COORD_W  = MAX_LOG2 + 1;
  localparam int unsigned ROW_W    = COORD_W + 1;
  localparam int unsigned IDX_W    = 21;

  localparam logic [LOG2_W-1:0] GRID_LOG2_RESET = LOG2_W'(6);
  localparam logic [LOG2_W-1:0] GRID_LOG2_MAX   = LOG2_W'(MAX_LOG2);
  localparam logic [LOG2_W-1:0] GRID_LOG2_MIN   = LOG2_W'(1);

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    PH_TOP    = 2'd0,
    PH_BOTTOM = 2'd1,
    PH_DEGEN  = 2'd2
  } phase_e;

endpackage

`default_nettype wire

// ===== rtl/core/grid_strip_index_generator.sv =====
// Grid strip index generator: serpentine triangle-strip index stream.
`timescale 1ns / 1ps
`default_nettype none
`include "grid_strip_index_generator_assert.svh"

// The block walks a square grid of 2^n+1 vertices per side (n from grid_log2) as one
// serpentine triangle strip. A start request latches the level of detail (saturated
// to n) and produces no output; each advance request produces one row-major vertex
// index, and the final degenerate index of the strip carries last_o. Advances while no
// strip is running, and a write of grid_log2, which abandons a running strip, produce
// nothing. One request is taken every clock while the result is not stalled; a request
// passes an input register and the walk logic, and its index is loaded into the result
// register unless a stalled result still holds that register. The walk counters are
// updated in that step, so back-to-back advances run at full rate. Write grid_log2
// only while no request is in flight.
module grid_strip_index_generator
  import gsig_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,

  input  wire logic              cfg_we_i,
  input  wire logic [LOG2_W-1:0] cfg_wdata_i,

  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              command_i,
  input  wire logic [LOG2_W-1:0] level_i,

  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [IDX_W-1:0]       vertex_index_o,
  output logic                   last_o
);

  logic [LOG2_W-1:0]  grid_log2_q;

  logic               req_vld_q;
  logic               req_cmd_q;
  logic [LOG2_W-1:0]  req_level_q;

  logic               active_q, active_d;
  logic [LOG2_W-1:0]  level_held_q, level_held_d;
  logic [COORD_W-1:0] row_pos_q, row_pos_d;
  logic [COORD_W-1:0] col_pos_q, col_pos_d;
  phase_e             phase_q, phase_d;

  logic               out_vld_q;
  logic [IDX_W-1:0]   out_idx_q;
  logic               out_last_q;

  logic               adv;
  logic               proc;
  logic               res_vld;
  logic [IDX_W-1:0]   res_idx;
  logic               res_last;

  logic [LOG2_W-1:0]  n_eff;
  logic [LOG2_W-1:0]  lv;
  logic [LOG2_W-1:0]  lv_start;
  logic [COORD_W-1:0] span;
  logic [COORD_W-1:0] step;
  logic [COORD_W-1:0] col_c;
  logic [COORD_W-1:0] row_shr;
  logic               reverse;
  logic [COORD_W-1:0] col;
  logic [ROW_W-1:0]   row_top;
  logic [ROW_W-1:0]   row_bot;
  logic [ROW_W-1:0]   col_next;
  logic               col_done;
  logic [ROW_W:0]     row_after;
  logic               strip_done;

  function automatic logic [IDX_W-1:0] vidx(input logic [ROW_W-1:0]   row,
                                            input logic [COORD_W-1:0] c,
                                            input logic [LOG2_W-1:0]  n);
    logic [IDX_W-1:0] r;
    r = IDX_W'(row);
    return (r << n) + r + IDX_W'(c);
  endfunction

  // The pipeline moves whenever the result register is free or being drained.
  assign adv        = !(out_vld_q && out_stall_i);
  assign proc       = req_vld_q && adv;
  assign in_stall_o = req_vld_q && !adv;

  always_comb begin
    if (grid_log2_q < GRID_LOG2_MIN) begin
      n_eff = GRID_LOG2_MIN;
    end else if (grid_log2_q > GRID_LOG2_MAX) begin
      n_eff = GRID_LOG2_MAX;
    end else begin
      n_eff = grid_log2_q;
    end
  end

  assign lv       = (level_held_q > n_eff) ? n_eff : level_held_q;
  assign lv_start = (req_level_q > n_eff) ? n_eff : req_level_q;
  assign span     = COORD_W'(1) << n_eff;
  assign step     = COORD_W'(1) << lv;
  assign col_c    = (col_pos_q > span) ? span : col_pos_q;
  assign row_shr  = row_pos_q >> lv;
  // Odd row pairs run from the right edge back to the left.
  assign reverse  = row_shr[0];
  assign col      = reverse ? (span - col_c) : col_c;

  assign row_top    = {1'b0, row_pos_q};
  assign row_bot    = {1'b0, row_pos_q} + {1'b0, step};
  assign col_next   = {1'b0, col_c} + {1'b0, step};
  assign col_done   = col_next > {1'b0, span};
  assign row_after  = {1'b0, row_bot} + {2'b00, step};
  assign strip_done = row_after > {2'b00, span};

  always_comb begin
    active_d     = active_q;
    level_held_d = level_held_q;
    row_pos_d    = row_pos_q;
    col_pos_d    = col_pos_q;
    phase_d      = phase_q;
    res_vld      = 1'b0;
    res_idx      = '0;
    res_last     = 1'b0;

    if (proc) begin
      if (req_cmd_q == CMD_START) begin
        level_held_d = lv_start;
        row_pos_d    = '0;
        col_pos_d    = '0;
        phase_d      = PH_TOP;
        active_d     = 1'b1;
      end else if (active_q) begin
        res_vld   = 1'b1;
        col_pos_d = col_c;
        case (phase_q)
          PH_BOTTOM: begin
            res_idx = vidx(row_bot, col, n_eff);
            if (col_done) begin
              phase_d = PH_DEGEN;
            end else begin
              col_pos_d = col_next[COORD_W-1:0];
              phase_d   = PH_TOP;
            end
          end
          PH_DEGEN: begin
            // Repeat the last bottom vertex to stitch to the next row pair.
            res_idx = vidx(row_bot, reverse ? '0 : span, n_eff);
            if (strip_done) begin
              res_last = 1'b1;
              active_d = 1'b0;
            end
            row_pos_d = row_bot[COORD_W-1:0];
            col_pos_d = '0;
            phase_d   = PH_TOP;
          end
          default: begin
            res_idx = vidx(row_top, col, n_eff);
            phase_d = PH_BOTTOM;
          end
        endcase
      end
    end

    if (cfg_we_i) begin
      active_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_log2_q  <= GRID_LOG2_RESET;
      req_vld_q    <= 1'b0;
      active_q     <= 1'b0;
      level_held_q <= '0;
      row_pos_q    <= '0;
      col_pos_q    <= '0;
      phase_q      <= PH_TOP;
      out_vld_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        grid_log2_q <= cfg_wdata_i;
      end
      if (!req_vld_q || adv) begin
        req_vld_q <= in_valid_i;
      end
      active_q     <= active_d;
      level_held_q <= level_held_d;
      row_pos_q    <= row_pos_d;
      col_pos_q    <= col_pos_d;
      phase_q      <= phase_d;
      if (adv) begin
        out_vld_q <= res_vld;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!req_vld_q || adv) begin
      req_cmd_q   <= command_i;
      req_level_q <= level_i;
    end
    if (adv) begin
      out_idx_q  <= res_idx;
      out_last_q <= res_last;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign vertex_index_o = out_idx_q;
  assign last_o         = out_last_q;

  `GSIG_ASSERT(a_last_ends_strip, (out_vld_q && out_last_q) |-> !active_q,
               "strip still running after its last index")
  `GSIG_ASSERT(a_level_in_range, active_q |-> (level_held_q <= n_eff),
               "held level exceeds grid size")
  `GSIG_ASSERT(a_col_in_range, active_q |-> (col_pos_q <= span),
               "column walked past the grid edge")
  `GSIG_ASSERT(a_degen_at_edge, (active_q && phase_q == PH_DEGEN) |-> col_done,
               "degenerate index pending before the row pair reached its edge")

endmodule

`default_nettype wire
